@@ rtl/core/ida_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ida_pkg
// Shared constants and types for the integer to decimal ASCII converter.
// ----------------------------------------------------------------------------
package ida_pkg;

    localparam int VALUE_W       = 64;
    localparam int DIGIT_W       = 4;
    localparam int DIGITS        = 20;
    localparam int BCD_W         = DIGITS * DIGIT_W;
    localparam int BITS_PER_STEP = 4;
    localparam int STEPS         = VALUE_W / BITS_PER_STEP;
    localparam int STEP_CNT_W    = $clog2(STEPS);
    localparam int POS_W         = 5;
    localparam int LEN_W         = 8;

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_NUL   = 8'h00;

    typedef logic [BCD_W-1:0]   t_bcd;
    typedef logic [VALUE_W-1:0] t_value;

endpackage

`default_nettype wire

@@ rtl/core/ida_bcd_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ida_bcd_unit
// Shift-and-add-three binary to BCD unit, several magnitude bits per cycle.
// ----------------------------------------------------------------------------
module ida_bcd_unit (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_load,
    input  wire ida_pkg::t_value i_mag,
    output logic                 o_done,
    output ida_pkg::t_bcd        o_bcd
);

    logic                                r_run;
    logic                                r_done;
    logic [ida_pkg::STEP_CNT_W-1:0]      r_cnt;
    ida_pkg::t_bcd                       r_bcd;
    ida_pkg::t_value                     r_bin;
    ida_pkg::t_bcd                       n_bcd;
    ida_pkg::t_value                     n_bin;

    always_comb begin
        n_bcd = r_bcd;
        n_bin = r_bin;
        for (int s = 0; s < ida_pkg::BITS_PER_STEP; s++) begin
            for (int d = 0; d < ida_pkg::DIGITS; d++) begin
                if (n_bcd[d*ida_pkg::DIGIT_W +: ida_pkg::DIGIT_W] >= 4'd5) begin
                    n_bcd[d*ida_pkg::DIGIT_W +: ida_pkg::DIGIT_W] =
                        n_bcd[d*ida_pkg::DIGIT_W +: ida_pkg::DIGIT_W] + 4'd3;
                end
            end
            {n_bcd, n_bin} = {n_bcd[ida_pkg::BCD_W-2:0], n_bin, 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_load) begin
                r_run <= 1'b1;
                r_cnt <= ida_pkg::STEP_CNT_W'(ida_pkg::STEPS - 1);
            end else if (r_run) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_bcd <= '0;
            r_bin <= i_mag;
        end else if (r_run) begin
            r_bcd <= n_bcd;
            r_bin <= n_bin;
        end
    end

    assign o_done = r_done;
    assign o_bcd  = r_bcd;

endmodule

`default_nettype wire

@@ rtl/core/integer_to_decimal_ascii.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// integer_to_decimal_ascii
// Converts a 64-bit value to decimal ASCII text, one character per result.
//
//   channel   ports                                          handshake
//   request   i_value_bits i_mode i_buffer_len               start, busy
//   result    o_char_byte o_position o_store o_last          o_strobe
//             o_overflow_error o_chars_written
//
// A request is converted in the BCD unit (4 bits a cycle over 64 bits), then
// checked in S_CHECK; an overflow result then shows for one cycle, otherwise
// S_EMIT shows one result a cycle, up to 21 results.
// busy rises after acceptance and falls as the last result is shown.
// Reset is synchronous, active low, and returns the sequencer to idle.
// Results cannot be held off by the receiver.
// ----------------------------------------------------------------------------
module integer_to_decimal_ascii #(
    parameter int MAX_BUFFER = 21
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic [63:0]                  i_value_bits,
    input  wire logic                         i_mode,
    input  wire logic [7:0]                   i_buffer_len,
    output logic                              o_strobe,
    output logic [7:0]                        o_char_byte,
    output logic [4:0]                        o_position,
    output logic                              o_store,
    output logic                              o_last,
    output logic                              o_overflow_error,
    output logic [4:0]                        o_chars_written
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_CONV  = 2'd1;
    localparam logic [1:0] S_CHECK = 2'd2;
    localparam logic [1:0] S_EMIT  = 2'd3;

    localparam logic [ida_pkg::LEN_W-1:0] MAX_LEN = ida_pkg::LEN_W'(MAX_BUFFER);

    logic [1:0]                  r_state;
    logic                        r_mode;
    logic                        r_neg;
    logic [ida_pkg::POS_W-1:0]   r_len;
    logic [ida_pkg::POS_W-1:0]   r_pos;
    logic [ida_pkg::POS_W-1:0]   r_dig_idx;
    logic                        r_dig_left;

    logic                        r_strobe;
    logic [7:0]                  r_char;
    logic [ida_pkg::POS_W-1:0]   r_position;
    logic                        r_store;
    logic                        r_last;
    logic                        r_err;
    logic [ida_pkg::POS_W-1:0]   r_count;

    logic                        w_accept;
    logic                        w_in_neg;
    ida_pkg::t_value             w_mag;
    logic [ida_pkg::POS_W-1:0]   w_len_clamp;
    logic                        w_done;
    ida_pkg::t_bcd               w_bcd;
    logic [ida_pkg::POS_W-1:0]   w_ndig;
    logic                        w_too_long;
    logic [ida_pkg::DIGIT_W-1:0] w_digit;

    assign w_accept    = start && !busy;
    assign w_in_neg    = !i_mode && i_value_bits[63];
    assign w_mag       = w_in_neg ? (64'd0 - i_value_bits) : i_value_bits;
    assign w_len_clamp = (i_buffer_len > MAX_LEN) ? ida_pkg::POS_W'(MAX_BUFFER)
                                                  : i_buffer_len[ida_pkg::POS_W-1:0];

    ida_bcd_unit u_bcd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_accept),
        .i_mag   (w_mag),
        .o_done  (w_done),
        .o_bcd   (w_bcd)
    );

    always_comb begin
        w_ndig = ida_pkg::POS_W'(1);
        for (int d = 0; d < ida_pkg::DIGITS; d++) begin
            if (w_bcd[d*ida_pkg::DIGIT_W +: ida_pkg::DIGIT_W] != '0) begin
                w_ndig = ida_pkg::POS_W'(d + 1);
            end
        end
    end

    assign w_too_long = ({1'b0, w_ndig} + (r_mode ? 6'd1 : 6'd2)) > {1'b0, r_len};
    assign w_digit    = w_bcd[{r_dig_idx, 2'b00} +: ida_pkg::DIGIT_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_state <= S_CONV;
                    end
                end
                S_CONV: begin
                    if (w_done) begin
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    if (r_len == '0 || w_too_long) begin
                        r_strobe <= 1'b1;
                        r_state  <= S_IDLE;
                    end else begin
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    r_strobe <= 1'b1;
                    if (!r_neg && !r_dig_left) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    r_mode <= i_mode;
                    r_neg  <= w_in_neg;
                    r_len  <= w_len_clamp;
                end
            end
            S_CHECK: begin
                r_pos      <= '0;
                r_dig_idx  <= w_ndig - 1'b1;
                r_dig_left <= 1'b1;
                r_char     <= ida_pkg::CHAR_NUL;
                r_position <= (r_len == '0) ? '0 : r_len - 1'b1;
                r_store    <= (r_len != '0);
                r_last     <= 1'b1;
                r_err      <= 1'b1;
                r_count    <= '0;
            end
            S_EMIT: begin
                r_position <= r_pos;
                r_store    <= 1'b1;
                r_err      <= 1'b0;
                r_pos      <= r_pos + 1'b1;
                if (r_neg) begin
                    r_char  <= ida_pkg::CHAR_MINUS;
                    r_last  <= 1'b0;
                    r_count <= '0;
                    r_neg   <= 1'b0;
                end else if (r_dig_left) begin
                    r_char  <= ida_pkg::CHAR_ZERO + {4'b0000, w_digit};
                    r_last  <= 1'b0;
                    r_count <= '0;
                    if (r_dig_idx == '0) begin
                        r_dig_left <= 1'b0;
                    end else begin
                        r_dig_idx <= r_dig_idx - 1'b1;
                    end
                end else begin
                    r_char  <= ida_pkg::CHAR_NUL;
                    r_last  <= 1'b1;
                    r_count <= r_pos;
                end
            end
            default: begin
            end
        endcase
    end

    assign busy             = (r_state != S_IDLE);
    assign o_strobe         = r_strobe;
    assign o_char_byte      = r_char;
    assign o_position       = r_position;
    assign o_store          = r_store;
    assign o_last           = r_last;
    assign o_overflow_error = r_err;
    assign o_chars_written  = r_count;

    a_last_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_last |-> r_state == S_IDLE)
        else $error("last result shown while sequencer still active");

    a_err_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_overflow_error |-> o_last && o_char_byte == ida_pkg::CHAR_NUL)
        else $error("overflow result not a single NUL");

    a_unstored_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_store |-> o_overflow_error && o_position == '0)
        else $error("unstored result outside zero-length case");

    a_accept_conv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_state == S_CONV && busy)
        else $error("accepted request did not start conversion");

    a_count_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_last && !o_overflow_error |-> o_chars_written == o_position)
        else $error("character count differs from NUL position");

endmodule

`default_nettype wire
